[design/pdc_pkg.sv]
package pdc_pkg;

  localparam int unsigned MaxOrder = 8;
  localparam logic [63:0] QOne = 64'h0000_0001_0000_0000;
  localparam logic [63:0] SatPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SatNeg = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] delay_time;
    logic [3:0]  approx_order;
  } pdc_in_t;

  typedef struct packed {
    logic [63:0] num_coeff;
    logic [63:0] den_coeff;
    logic [3:0]  power_index;
    logic        last;
  } pdc_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StEmit
  } pdc_state_e;

endpackage

[design/pdc_divider.sv]
module pdc_divider import pdc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] dividend_i,
  input  logic [36:0]  divisor_i,
  output logic         done_o,
  output logic         sat_o,
  output logic [63:0]  quot_o
);

  logic [127:0] dvd_q, dvd_d;
  logic [37:0]  rem_q, rem_d;
  logic [36:0]  dv_q, dv_d;
  logic [63:0]  quot_q, quot_d;
  logic [6:0]   bit_q, bit_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic         sat_q, sat_d;
  logic [37:0]  shifted;

  assign shifted = {rem_q[36:0], dvd_q[127]};

  // Restoring division, one quotient bit per cycle from the top.
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    quot_d = quot_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    if (start_i) begin
      dvd_d  = dividend_i;
      dv_d   = divisor_i;
      rem_d  = '0;
      quot_d = '0;
      bit_d  = 7'd127;
      busy_d = 1'b1;
      sat_d  = 1'b0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[126:0], 1'b0};
      rem_d = shifted;
      if (shifted >= {1'b0, dv_q}) begin
        rem_d = shifted - {1'b0, dv_q};
        if (bit_q >= 7'd63) begin
          sat_d  = 1'b1;
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          quot_d = quot_q | (64'd1 << bit_q[5:0]);
        end
      end
      if (busy_d) begin
        if (bit_q == 7'd0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        bit_d = bit_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    quot_q <= quot_d;
    bit_q  <= bit_d;
    sat_q  <= sat_d;
  end

  assign done_o = done_q;
  assign sat_o  = sat_q;
  assign quot_o = quot_q;

endmodule

[design/pade_delay_coefficients.sv]
// Channel  | valid       | stall       | payload
// input    | in_valid_i  | in_stall_o  | in_data_i  (pdc_in_t)
// output   | out_valid_o | out_stall_i | out_data_o (pdc_out_t)
// config   | cfg_we_i    | -           | cfg_wdata_i (eps_threshold)
// One item yields N+1 transactions, or a single one for a small delay. Each
// recurrence step follows its emit state with a multiply state (StMul) and a
// run of the shared bit-serial divider (load, quotient bits from the top,
// done); a saturating step ends the divider early, and the later pairs are
// then emitted saturated without further recurrence steps. The input stalls
// until the last pair has been taken. Output stall holds the current pair.
// Reset clears the sequencer and sets eps_threshold to 1.
module pade_delay_coefficients import pdc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pdc_in_t   in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pdc_out_t  out_data_o,
  input  logic      cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  pdc_state_e   state_q, state_d;
  logic [15:0]  eps_q;
  logic [31:0]  t_q, t_d;
  logic [3:0]   n_q, n_d;
  logic [3:0]   p_q, p_d;
  logic [63:0]  c_q, c_d;
  logic         sat_q, sat_d;
  logic [25:0]  s_q, s_d;
  logic [36:0]  dv_q, dv_d;
  logic [95:0]  t1_q, t1_d;
  logic [57:0]  t0_q, t0_d;
  logic [127:0] prod;
  logic [3:0]   n_in, k;
  logic [4:0]   mterm;
  logic         div_start;
  logic         div_done;
  logic         div_sat;
  logic         div_run_q;
  logic [63:0]  quot;

  assign n_in = (in_data_i.approx_order > 4'(MaxOrder)) ? 4'(MaxOrder)
                                                          : in_data_i.approx_order;
  assign k = p_q;
  assign mterm = {n_q, 1'b0} - {1'b0, k} + 5'd1;
  assign prod = {t1_q, 32'd0} + {70'd0, t0_q};

  pdc_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(prod), .divisor_i(dv_q),
    .done_o(div_done), .sat_o(div_sat), .quot_o(quot)
  );

  // Sequencer: emit pair at p, then step the recurrence down to p-1.
  always_comb begin
    state_d = state_q;
    t_d = t_q; n_d = n_q; p_d = p_q; c_d = c_q; sat_d = sat_q;
    s_d = s_q; dv_d = dv_q; t1_d = t1_q; t0_d = t0_q;
    div_start = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          t_d = in_data_i.delay_time;
          c_d = QOne;
          sat_d = 1'b0;
          if (in_data_i.delay_time <= {16'd0, eps_q}) begin
            n_d = '0;
          end else begin
            n_d = n_in;
          end
          p_d = n_d;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!out_stall_i) begin
          if (p_q == 4'd0) begin
            state_d = StIdle;
          end else if (sat_q) begin
            p_d = p_q - 4'd1;
          end else begin
            // k equals the current power p.
            s_d  = {10'(mterm) * 10'(k), 16'd0};
            dv_d = 37'({1'b0, n_q} - {1'b0, k} + 5'd1) * 37'(t_q);
            state_d = StMul;
          end
        end
      end
      StMul: begin
        t1_d = 96'(c_q[63:32]) * 96'(s_q);
        t0_d = 58'(c_q[31:0]) * 58'(s_q);
        state_d = StDiv;
      end
      StDiv: begin
        state_d = StDiv;
      end
      default: state_d = StIdle;
    endcase
    // Divider launch in the first StDiv cycle, once the products are registered.
    if (state_q == StDiv && !div_run_q) div_start = 1'b1;
    if (state_q == StDiv && div_done) begin
      sat_d = div_sat;
      c_d = quot;
      p_d = p_q - 4'd1;
      state_d = StEmit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_run_q <= 1'b0;
    end else if (state_q != StDiv || div_done) begin
      div_run_q <= 1'b0;
    end else begin
      div_run_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      eps_q <= 16'd1;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) eps_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d; n_q <= n_d; p_q <= p_d; c_q <= c_d; sat_q <= sat_d;
    s_q <= s_d; dv_q <= dv_d; t1_q <= t1_d; t0_q <= t0_d;
  end

  // Output pair from the current magnitude and power.
  always_comb begin
    out_data_o.den_coeff = sat_q ? SatPos : c_q;
    if (p_q[0]) begin
      out_data_o.num_coeff = sat_q ? SatNeg : (64'd0 - c_q);
    end else begin
      out_data_o.num_coeff = out_data_o.den_coeff;
    end
    out_data_o.power_index = p_q;
    out_data_o.last = (p_q == 4'd0);
  end

  assign out_valid_o = (state_q == StEmit);
  assign in_stall_o = (state_q != StIdle);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("output while input open");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last) |=> !out_valid_o)
    else $error("pair after last");
  a_power_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last) |=> !out_valid_o ||
    out_data_o.power_index == $past(out_data_o.power_index) - 4'd1)
    else $error("power did not step down");
`endif

endmodule
